[rtl/tsd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsd_pkg: shared types and constants for the translated spin density block
// Field widths, default fixed-point formats and the word passed from the
// front part to the back part.
// ----------------------------------------------------------------------------
package tsd_pkg;

  localparam int RHO_W        = 32;
  localparam int PI_W         = 64;
  localparam int RAT_FRAC_DEF = 16;
  localparam int RATIO_W      = RAT_FRAC_DEF + 1;
  localparam int QUEUE_DEPTH  = 4;

  // classified word handed from front to back
  typedef struct packed {
    logic             zero;     // below threshold or rho zero: all outputs zero
    logic             sat;      // ratio known to be 1.0
    logic             nonpos;   // ratio known to be 0
    logic [RHO_W-1:0] rho;
    logic [PI_W-1:0]  num;      // 4*pi, valid when not zero/sat/nonpos
  } tsd_word_t;

endpackage

[rtl/translated_spin_density_point.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// translated_spin_density_point: on-top ratio, zeta and spin split per point
//
//   channel  ports                                   handshake
//   input    in_rho, in_pair_density                 in_push / in_full
//   result   out_on_top_ratio, out_zeta,
//            out_alpha_density, out_beta_density    out_empty / out_pop
//   config   cfg_wdata                               cfg_we
//
// One word is accepted per cycle while in_full is low. The divider makes one
// quotient bit a stage and the square root one root bit a stage. Reset
// clears control state only; no clearing pass. A stalled result side fills
// the output buffer, then the front queue, then raises in_full.
// ----------------------------------------------------------------------------
module translated_spin_density_point import tsd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic [RHO_W-1:0]        in_rho,
  input  logic signed [PI_W-1:0]  in_pair_density,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic [RATIO_W-1:0]      out_on_top_ratio,
  output logic [RATIO_W-1:0]      out_zeta,
  output logic [RHO_W-1:0]        out_alpha_density,
  output logic [RHO_W-1:0]        out_beta_density,
  input  logic                    cfg_we,
  input  logic [RHO_W-1:0]        cfg_wdata
);

  logic      fw_valid, fw_ready, bw_valid, bw_ready;
  tsd_word_t fw_word, bw_word;

  tsd_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_rho, .in_pair_density,
    .cfg_we, .cfg_wdata, .fw_valid, .fw_word, .fw_ready
  );

  tsd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n,
    .wr_valid(fw_valid), .wr_word(fw_word), .wr_ready(fw_ready),
    .rd_valid(bw_valid), .rd_word(bw_word), .rd_ready(bw_ready)
  );

  tsd_back u_back (
    .clk, .rst_n, .bw_valid, .bw_word, .bw_ready,
    .out_empty, .out_pop, .out_on_top_ratio, .out_zeta,
    .out_alpha_density, .out_beta_density
  );

endmodule

[rtl/tsd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsd_front: input stage and classifier
// Registers one input word, checks it against the threshold and flags the
// special cases that need no division.
// ----------------------------------------------------------------------------
module tsd_front import tsd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic [RHO_W-1:0]        in_rho,
  input  logic signed [PI_W-1:0]  in_pair_density,
  input  logic                    cfg_we,
  input  logic [RHO_W-1:0]        cfg_wdata,
  output logic                    fw_valid,
  output tsd_word_t               fw_word,
  input  logic                    fw_ready
);

  logic [RHO_W-1:0] thr_r;
  logic             vld_r;
  tsd_word_t        word_r;
  tsd_word_t        word_nxt;
  logic [PI_W-1:0]  pib;

  assign in_full  = vld_r && !fw_ready;
  assign fw_valid = vld_r;
  assign fw_word  = word_r;
  assign pib      = in_pair_density;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= RHO_W'(1);
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  // classify
  always_comb begin
    word_nxt.rho    = in_rho;
    word_nxt.zero   = (in_rho < thr_r) || (in_rho == '0);
    word_nxt.nonpos = pib[PI_W-1] || (pib == '0);
    word_nxt.sat    = !word_nxt.nonpos && (pib[PI_W-2] == 1'b1);
    word_nxt.num    = {pib[PI_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!in_full) begin
      vld_r <= in_push;
    end
  end

  always_ff @(posedge clk) begin
    if (in_push && !in_full) begin
      word_r <= word_nxt;
    end
  end

endmodule

[rtl/tsd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsd_queue: short FIFO between front and back
// Lets either side stall without stopping the other.
// ----------------------------------------------------------------------------
module tsd_queue import tsd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_valid,
  input  tsd_word_t wr_word,
  output logic      wr_ready,
  output logic      rd_valid,
  output tsd_word_t rd_word,
  input  logic      rd_ready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  tsd_word_t       mem [DEPTH];
  logic [AW-1:0]   wp_r, rp_r;
  logic [AW:0]     cnt_r;
  logic            wr_en, rd_en;

  assign wr_ready = (cnt_r != (AW+1)'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_word  = mem[rp_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp_r] <= wr_word;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + AW'(1);
      if (rd_en) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end

endmodule

[rtl/tsd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsd_back: pipelined arithmetic
// rho^2, a restoring divider of one quotient bit a stage, a square root of
// one result bit a stage, the split products, then an output skid FIFO.
// ----------------------------------------------------------------------------
module tsd_back import tsd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 bw_valid,
  input  tsd_word_t            bw_word,
  output logic                 bw_ready,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [RATIO_W-1:0]   out_on_top_ratio,
  output logic [RATIO_W-1:0]   out_zeta,
  output logic [RHO_W-1:0]     out_alpha_density,
  output logic [RHO_W-1:0]     out_beta_density
);

  localparam int RAT_FRAC = RAT_FRAC_DEF;
  localparam int DS   = RAT_FRAC;          // divider stages
  localparam int SS   = RAT_FRAC + 1;      // sqrt stages (root bits)
  localparam int LAT  = 2 + DS + 1 + SS + 1;
  localparam int OD   = LAT + 2;           // output buffer depth
  localparam int OAW  = $clog2(OD);
  localparam int RW   = 2 * RAT_FRAC + 2;  // sqrt radicand width
  localparam logic [RATIO_W-1:0] ONE = RATIO_W'(1) << RAT_FRAC;

  // credit: items in flight plus buffered never exceed OD
  logic [OAW:0] cred_r;
  logic         adv, pop_en;

  assign bw_ready = (cred_r != '0);
  assign adv      = bw_valid && bw_ready;

  // ---------------- stage A: rho^2 ----------------
  logic             a_v_r, a_z_r, a_s_r, a_n_r;
  logic [RHO_W-1:0] a_rho_r;
  logic [PI_W-1:0]  a_num_r, a_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else        a_v_r <= adv;
  end
  always_ff @(posedge clk) begin
    a_z_r   <= bw_word.zero;
    a_s_r   <= bw_word.sat;
    a_n_r   <= bw_word.nonpos;
    a_rho_r <= bw_word.rho;
    a_num_r <= bw_word.num;
    a_sq_r  <= PI_W'(bw_word.rho) * PI_W'(bw_word.rho);
  end

  // ---------------- stage B: pre-compare ----------------
  logic             b_v_r, b_z_r, b_one_r, b_n_r;
  logic [RHO_W-1:0] b_rho_r;
  logic [PI_W-1:0]  b_num_r, b_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b_v_r <= 1'b0;
    else        b_v_r <= a_v_r;
  end
  always_ff @(posedge clk) begin
    b_z_r   <= a_z_r;
    b_n_r   <= a_n_r;
    b_one_r <= !a_n_r && (a_s_r || (a_num_r >= a_sq_r));
    b_rho_r <= a_rho_r;
    b_num_r <= a_num_r;
    b_sq_r  <= a_sq_r;
  end

  // ---------------- divider: one quotient bit a stage ----------------
  logic             d_v_r   [DS+1];
  logic             d_z_r   [DS+1];
  logic             d_one_r [DS+1];
  logic             d_n_r   [DS+1];
  logic [RHO_W-1:0] d_rho_r [DS+1];
  logic [PI_W-1:0]  d_r_r   [DS+1];
  logic [PI_W-1:0]  d_sq_r  [DS+1];
  logic [RAT_FRAC-1:0] d_q_r [DS+1];

  always_comb begin
    d_v_r[0]   = b_v_r;
    d_z_r[0]   = b_z_r;
    d_one_r[0] = b_one_r;
    d_n_r[0]   = b_n_r;
    d_rho_r[0] = b_rho_r;
    d_r_r[0]   = b_num_r;
    d_sq_r[0]  = b_sq_r;
    d_q_r[0]   = '0;
  end

  for (genvar i = 0; i < DS; i++) begin : g_div
    logic            cy;
    logic [PI_W-1:0] sh;
    logic            take;
    assign cy   = d_r_r[i][PI_W-1];
    assign sh   = {d_r_r[i][PI_W-2:0], 1'b0};
    assign take = cy || (sh >= d_sq_r[i]);
    always_ff @(posedge clk) begin
      if (!rst_n) d_v_r[i+1] <= 1'b0;
      else        d_v_r[i+1] <= d_v_r[i];
    end
    always_ff @(posedge clk) begin
      d_z_r[i+1]   <= d_z_r[i];
      d_one_r[i+1] <= d_one_r[i];
      d_n_r[i+1]   <= d_n_r[i];
      d_rho_r[i+1] <= d_rho_r[i];
      d_sq_r[i+1]  <= d_sq_r[i];
      d_r_r[i+1]   <= take ? sh - d_sq_r[i] : sh;
      d_q_r[i+1]   <= {d_q_r[i][RAT_FRAC-2:0], take};
    end
  end

  // ---------------- ratio select and radicand ----------------
  logic               r_v_r, r_z_r;
  logic [RHO_W-1:0]   r_rho_r;
  logic [RATIO_W-1:0] r_ratio_r;
  logic [RATIO_W-1:0] ratio_c;

  always_comb begin
    if (d_n_r[DS])        ratio_c = '0;
    else if (d_one_r[DS]) ratio_c = ONE;
    else                  ratio_c = RATIO_W'(d_q_r[DS]);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) r_v_r <= 1'b0;
    else        r_v_r <= d_v_r[DS];
  end
  always_ff @(posedge clk) begin
    r_z_r     <= d_z_r[DS];
    r_rho_r   <= d_rho_r[DS];
    r_ratio_r <= ratio_c;
  end

  // ---------------- square root: one root bit a stage ----------------
  logic               s_v_r   [SS+1];
  logic               s_z_r   [SS+1];
  logic [RHO_W-1:0]   s_rho_r [SS+1];
  logic [RATIO_W-1:0] s_rat_r [SS+1];
  logic [RW-1:0]      s_rem_r [SS+1];
  logic [RATIO_W-1:0] s_root_r[SS+1];

  always_comb begin
    s_v_r[0]    = r_v_r;
    s_z_r[0]    = r_z_r;
    s_rho_r[0]  = r_rho_r;
    s_rat_r[0]  = r_ratio_r;
    s_rem_r[0]  = RW'(ONE - r_ratio_r) << RAT_FRAC;
    s_root_r[0] = '0;
  end

  for (genvar k = 0; k < SS; k++) begin : g_sqrt
    localparam int B = SS - 1 - k;   // root bit decided here
    logic [RW-1:0] trial;
    logic          ok;
    assign trial = (RW'(s_root_r[k]) << (B + 1)) + (RW'(1) << (2 * B));
    assign ok    = s_rem_r[k] >= trial;
    always_ff @(posedge clk) begin
      if (!rst_n) s_v_r[k+1] <= 1'b0;
      else        s_v_r[k+1] <= s_v_r[k];
    end
    always_ff @(posedge clk) begin
      s_z_r[k+1]    <= s_z_r[k];
      s_rho_r[k+1]  <= s_rho_r[k];
      s_rat_r[k+1]  <= s_rat_r[k];
      s_rem_r[k+1]  <= ok ? s_rem_r[k] - trial : s_rem_r[k];
      s_root_r[k+1] <= s_root_r[k] | (ok ? (RATIO_W'(1) << B) : '0);
    end
  end

  // ---------------- split products ----------------
  logic               p_v_r;
  logic [RATIO_W-1:0] p_rat_r, p_zeta_r;
  logic [RHO_W-1:0]   p_a_r, p_b_r;
  logic [RATIO_W-1:0] zc;
  logic [RHO_W+RATIO_W:0] pa, pb;

  assign zc = (s_root_r[SS] > ONE) ? ONE : s_root_r[SS];
  assign pa = (RHO_W+RATIO_W+1)'(s_rho_r[SS]) * (RHO_W+RATIO_W+1)'(ONE + zc);
  assign pb = (RHO_W+RATIO_W+1)'(s_rho_r[SS]) * (RHO_W+RATIO_W+1)'(ONE - zc);

  always_ff @(posedge clk) begin
    if (!rst_n) p_v_r <= 1'b0;
    else        p_v_r <= s_v_r[SS];
  end
  always_ff @(posedge clk) begin
    p_rat_r  <= s_z_r[SS] ? '0 : s_rat_r[SS];
    p_zeta_r <= s_z_r[SS] ? '0 : zc;
    p_a_r    <= s_z_r[SS] ? '0 : RHO_W'(pa >> (RAT_FRAC + 1));
    p_b_r    <= s_z_r[SS] ? '0 : RHO_W'(pb >> (RAT_FRAC + 1));
  end

  // ---------------- output buffer ----------------
  typedef struct packed {
    logic [RATIO_W-1:0] rat;
    logic [RATIO_W-1:0] zeta;
    logic [RHO_W-1:0]   a;
    logic [RHO_W-1:0]   b;
  } res_t;

  res_t           ob [OD];
  res_t           head_r;
  res_t           p_res;
  logic           head_v_r;
  logic [OAW-1:0] owp_r, orp_r;
  logic [OAW:0]   mcnt_r;
  logic           load, from_mem, to_mem;

  // head register holds the oldest word; the memory holds the rest
  assign p_res     = '{rat: p_rat_r, zeta: p_zeta_r, a: p_a_r, b: p_b_r};
  assign out_empty = !head_v_r;
  assign pop_en    = out_pop && head_v_r;
  assign load      = !head_v_r || pop_en;
  assign from_mem  = load && (mcnt_r != '0);
  assign to_mem    = p_v_r && !(load && (mcnt_r == '0));
  assign out_on_top_ratio  = head_r.rat;
  assign out_zeta          = head_r.zeta;
  assign out_alpha_density = head_r.a;
  assign out_beta_density  = head_r.b;

  // storage and head load; a word skips the memory when it is empty and the head loads
  always_ff @(posedge clk) begin
    if (to_mem) ob[owp_r] <= p_res;
    if (from_mem)               head_r <= ob[orp_r];
    else if (load && p_v_r)     head_r <= p_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      owp_r    <= '0;
      orp_r    <= '0;
      mcnt_r   <= '0;
      cred_r   <= (OAW+1)'(OD);
    end else begin
      if (load)     head_v_r <= from_mem || p_v_r;
      if (to_mem)   owp_r <= (owp_r == OAW'(OD-1)) ? '0 : owp_r + OAW'(1);
      if (from_mem) orp_r <= (orp_r == OAW'(OD-1)) ? '0 : orp_r + OAW'(1);
      mcnt_r <= mcnt_r + (OAW+1)'(to_mem) - (OAW+1)'(from_mem);
      cred_r <= cred_r - (OAW+1)'(adv) + (OAW+1)'(pop_en);
    end
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for translated_spin_density_point
// Pushes grid points (rho, pi) through the queue-style input, predicts the
// clamped on-top ratio, zeta and the alpha/beta split in fixed point, and
// compares every popped word in order. Sender and receiver idle at random;
// the density threshold is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import tsd_pkg::*;

  localparam int RB      = RAT_FRAC_DEF;
  localparam int LATENCY = RB * 2 + 7;

  typedef struct {
    logic [RATIO_W-1:0] ratio;
    logic [RATIO_W-1:0] zeta;
    logic [RHO_W-1:0]   alpha;
    logic [RHO_W-1:0]   beta;
  } spin_split_t;

  int n_errors = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    n_errors++;
  endtask

  // floor(sqrt(v)), bitwise
  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] res, bit_w;
    res   = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v   = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  // clamped 4*pi/rho^2 with RB fraction bits
  function automatic logic [63:0] clamped_ratio(input logic [63:0] pi_bits,
                                                input logic [63:0] rho2);
    logic [63:0] num, rem, q;
    logic        carry;
    q = 0;
    if (pi_bits[63] || pi_bits == 0) return 0;
    if (pi_bits >= (64'd1 << 62)) return 64'd1 << RB;
    num = pi_bits << 2;
    if (num >= rho2) return 64'd1 << RB;
    rem = num;
    for (int i = 0; i < RB; i++) begin
      carry = rem[63];
      rem   = rem << 1;
      q     = q << 1;
      if (carry || rem >= rho2) begin
        rem  = rem - rho2;
        q[0] = 1'b1;
      end
    end
    return (q > (64'd1 << RB)) ? (64'd1 << RB) : q;
  endfunction

  class spin_scoreboard;
    spin_split_t  pending[$];
    logic [31:0]  threshold = 1;

    function void note_point(logic [31:0] rho, logic [63:0] pi_bits);
      spin_split_t e;
      logic [63:0] r, z, one;
      one = 64'd1 << RB;
      if (rho < threshold || rho == 0) begin
        e = '{0, 0, 0, 0};
      end else begin
        r = clamped_ratio(pi_bits, 64'(rho) * 64'(rho));
        z = floor_root((one - r) << RB);
        if (z > one) z = one;
        e.ratio = r[RATIO_W-1:0];
        e.zeta  = z[RATIO_W-1:0];
        e.alpha = 32'((64'(rho) * (one + z)) >> (RB + 1));
        e.beta  = 32'((64'(rho) * (one - z)) >> (RB + 1));
      end
      pending.push_back(e);
    endfunction

    task check_word(spin_split_t got);
      spin_split_t e;
      if (pending.size() == 0) begin
        report_mismatch("result word with nothing expected");
        return;
      end
      e = pending.pop_front();
      if (got.ratio !== e.ratio)
        report_mismatch($sformatf("ratio %0d exp %0d", got.ratio, e.ratio));
      if (got.zeta !== e.zeta)
        report_mismatch($sformatf("zeta %0d exp %0d", got.zeta, e.zeta));
      if (got.alpha !== e.alpha)
        report_mismatch($sformatf("alpha %0h exp %0h", got.alpha, e.alpha));
      if (got.beta !== e.beta)
        report_mismatch($sformatf("beta %0h exp %0h", got.beta, e.beta));
    endtask
  endclass

  logic clk = 0, rst_n = 0;
  logic in_push = 0, in_full, out_empty, out_pop = 0, cfg_we = 0;
  logic [RHO_W-1:0] in_rho = 0, cfg_wdata = 0;
  logic signed [PI_W-1:0] in_pair_density = 0;
  logic [RATIO_W-1:0] out_on_top_ratio, out_zeta;
  logic [RHO_W-1:0] out_alpha_density, out_beta_density;

  spin_scoreboard sb = new();

  translated_spin_density_point DUT (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_rho(in_rho), .in_pair_density(in_pair_density),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_on_top_ratio(out_on_top_ratio), .out_zeta(out_zeta),
    .out_alpha_density(out_alpha_density), .out_beta_density(out_beta_density),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // push one point; may idle first, push stays high across back-to-back words
  task automatic push_point(logic [31:0] rho, logic [63:0] pi_bits, bit may_idle);
    int gap;
    gap = may_idle ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push         <= 1'b1;
    in_rho          <= rho;
    in_pair_density <= pi_bits;
    do @(posedge clk); while (in_full);
    sb.note_point(rho, pi_bits);
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_threshold(logic [31:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.threshold = value;
  endtask

  // random point: pi mostly near rho^2/4 so the divider sees real work
  task automatic random_point(bit may_idle);
    logic [31:0] rho;
    logic [63:0] pi_bits, sq;
    int sel;
    sel = $urandom_range(0, 9);
    rho = (sel < 3) ? 32'($urandom_range(0, 4095)) : $urandom();
    sq  = 64'(rho) * 64'(rho);
    case ($urandom_range(0, 5))
      0: pi_bits = {$urandom(), $urandom()};
      1: pi_bits = -64'($urandom());
      default: begin
        pi_bits = (sq >> 2) - (sq >> $urandom_range(2, 40)) + 64'($urandom_range(0, 3));
      end
    endcase
    push_point(rho, pi_bits, may_idle);
  endtask

  // receiver: random stalls, runs of no stall
  initial begin : receiver
    spin_split_t got;
    int gap;
    @(posedge rst_n);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      got = '{out_on_top_ratio, out_zeta, out_alpha_density, out_beta_density};
      sb.check_word(got);
    end
  end

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes and special cases
    push_point(0, 0, 0);                                // zero density
    push_point(1, 64'd1, 0);
    push_point(32'hFFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 0); // large pi
    push_point(32'hFFFF_FFFF, 64'h8000_0000_0000_0000, 0); // negative pi
    push_point(32'h0010_0000, 64'h0000_0400_0000_0000, 0); // R = 16, clamped to 1
    push_point(32'h0010_0000, 64'h0000_01FF_FFFF_FFFF, 0);
    push_point(32'h0010_0000, 64'h0000_0000_0000_0001, 0);
    push_point(32'h0010_0000, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    push_point(32'hFFFF_FFFF, 64'h3FFF_FFFF_FFFF_FFFF, 0);
    push_point(32'hFFFF_FFFF, 64'h4000_0000_0000_0000, 0);
    push_point(32'hAAAA_5555, 64'h5555_AAAA_5555_AAAA, 0);

    write_threshold(32'd0);                             // rho = 0 is still zeroed at threshold 0
    push_point(0, 64'd5, 0);
    push_point(1, 64'd0, 0);
    write_threshold(32'hFFFF_FFFF);
    push_point(32'hFFFF_FFFE, 64'd100, 0);              // below threshold
    push_point(32'hFFFF_FFFF, 64'd100, 0);
    write_threshold(32'h0008_0000);
    push_point(32'h0007_FFFF, 64'd1, 0);
    push_point(32'h0008_0000, 64'd1, 0);

    // random phases under several thresholds
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_threshold(32'd1);
        1: write_threshold(32'd0);
        2: write_threshold($urandom_range(1, 4096));
        3: write_threshold($urandom());
        default: write_threshold(32'd1);
      endcase
      for (int i = 0; i < 300; i++) begin
        if (i == 150) wait_drained();                   // sender waits for drain
        random_point((i % 100) >= 30);                  // back-to-back stretches
      end
    end
    wait_drained();
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

[filelist.f]
rtl/tsd_pkg.sv
rtl/tsd_front.sv
rtl/tsd_queue.sv
rtl/tsd_back.sv
rtl/translated_spin_density_point.sv
verif/tb_top.sv
